// ===== sv/g4t_pkg.sv =====
// g4t_pkg: shared constants, register codes and types for the glyph tile unit
// used by every module of the unit but g4t_ram; depends on nothing
`default_nettype none

package g4t_pkg;

   localparam int MAX_STREAM_BYTES = 32;
   localparam int CELL_SIZE        = 16;
   localparam int WORD_COUNT       = 32;
   localparam int JOBQ_DEPTH       = 2;

   localparam int ADDR_W    = $clog2(MAX_STREAM_BYTES);
   localparam int COUNT_W   = $clog2(MAX_STREAM_BYTES + 1);
   localparam int JOBQ_PW   = $clog2(JOBQ_DEPTH);
   localparam int JOBQ_CW   = $clog2(JOBQ_DEPTH + 1);
   localparam int CFG_IDX_W = 2;
   localparam int CFG_DATA_W = 5;

   localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH = 2'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_ROWS  = 2'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET  = 2'd2;

   localparam logic [4:0] RESET_GLYPH_WIDTH = 5'd11;
   localparam logic [4:0] RESET_GLYPH_ROWS  = 5'd11;
   localparam logic [3:0] RESET_ROW_OFFSET  = 4'd1;

   localparam logic [3:0] PIX_INK    = 4'd15;
   localparam logic [3:0] PIX_SHADOW = 4'd14;
   localparam logic [3:0] PIX_EMPTY  = 4'd0;

   localparam logic [4:0] WORD_LAST = 5'd31;

   typedef struct packed {
      logic [4:0] glyph_width;
      logic [4:0] glyph_rows;
      logic [3:0] row_offset;
   } job_type;

endpackage

`default_nettype wire

// ===== sv/g4t_ram.sv =====
// g4t_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module g4t_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/g4t_front.sv =====
// g4t_front: accepts stream bytes into the bit buffer, holds the config registers
// and queues one job per glyph; depends on g4t_pkg
`default_nettype none

module g4t_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [7:0]                        req_stream_byte,
   input  wire logic                              req_stream_last,
   input  wire logic                              csr_we,
   input  wire logic [g4t_pkg::CFG_IDX_W-1:0]     csr_index,
   input  wire logic [g4t_pkg::CFG_DATA_W-1:0]    csr_data,
   output logic                                   ram_wr_en,
   output logic      [g4t_pkg::ADDR_W-1:0]        ram_wr_addr,
   output logic      [7:0]                        ram_wr_data,
   output logic                                   job_push,
   output g4t_pkg::job_type                       job_out,
   input  wire logic                              job_full,
   input  wire logic                              map_done
);

   logic [4:0]                    width_ff, width_in;
   logic [4:0]                    rows_ff, rows_in;
   logic [3:0]                    offset_ff, offset_in;
   logic [g4t_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                          busy_ff, busy_in;
   logic                          accept;
   logic                          room;

   assign req_ready = !busy_ff && !job_full;
   assign accept    = req_valid && req_ready;
   assign room      = count_ff < g4t_pkg::COUNT_W'(g4t_pkg::MAX_STREAM_BYTES);

   assign ram_wr_en   = accept && room;
   assign ram_wr_addr = count_ff[g4t_pkg::ADDR_W-1:0];
   assign ram_wr_data = req_stream_byte;

   assign job_push             = accept && req_stream_last;
   assign job_out.glyph_width  = width_ff;
   assign job_out.glyph_rows   = rows_ff;
   assign job_out.row_offset   = offset_ff;

   always_comb begin
      width_in  = width_ff;
      rows_in   = rows_ff;
      offset_in = offset_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      if (csr_we) begin
         case (csr_index)
            g4t_pkg::CFG_GLYPH_WIDTH: width_in  = csr_data[4:0];
            g4t_pkg::CFG_GLYPH_ROWS:  rows_in   = csr_data[4:0];
            g4t_pkg::CFG_ROW_OFFSET:  offset_in = csr_data[3:0];
            default: ;
         endcase
      end
      if (map_done) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         if (room) begin
            count_in = count_ff + g4t_pkg::COUNT_W'(1);
         end
         if (req_stream_last) begin
            count_in = '0;
            busy_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= g4t_pkg::RESET_GLYPH_WIDTH;
         rows_ff   <= g4t_pkg::RESET_GLYPH_ROWS;
         offset_ff <= g4t_pkg::RESET_ROW_OFFSET;
         count_ff  <= '0;
         busy_ff   <= 1'b0;
      end else begin
         width_ff  <= width_in;
         rows_ff   <= rows_in;
         offset_ff <= offset_in;
         count_ff  <= count_in;
         busy_ff   <= busy_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/g4t_jobq.sv =====
// g4t_jobq: small fifo of glyph jobs between front and back
// depends on g4t_pkg
`default_nettype none

module g4t_jobq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire g4t_pkg::job_type  push_job,
   output logic                   full,
   input  wire logic              pop,
   output g4t_pkg::job_type       pop_job,
   output logic                   empty
);

   g4t_pkg::job_type              entry_ff [g4t_pkg::JOBQ_DEPTH];
   logic [g4t_pkg::JOBQ_PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [g4t_pkg::JOBQ_PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [g4t_pkg::JOBQ_CW-1:0]   level_ff, level_in;
   logic                          do_push;
   logic                          do_pop;

   assign full    = level_ff == g4t_pkg::JOBQ_CW'(g4t_pkg::JOBQ_DEPTH);
   assign empty   = level_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == g4t_pkg::JOBQ_PW'(g4t_pkg::JOBQ_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + g4t_pkg::JOBQ_PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == g4t_pkg::JOBQ_PW'(g4t_pkg::JOBQ_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + g4t_pkg::JOBQ_PW'(1);
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + g4t_pkg::JOBQ_CW'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - g4t_pkg::JOBQ_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== sv/g4t_back.sv =====
// g4t_back: builds the 16x16 ink map from the bit buffer, then emits the shadowed
// 4bpp tile words through an output register; depends on g4t_pkg
`default_nettype none

module g4t_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        job_empty,
   input  wire g4t_pkg::job_type            job_in,
   output logic                             job_pop,
   output logic                             map_done,
   output logic      [g4t_pkg::ADDR_W-1:0]  ram_rd_addr,
   input  wire logic [7:0]                  ram_rd_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [31:0]                 rsp_tile_word,
   output logic      [4:0]                  rsp_word_index,
   output logic                             rsp_cell_last
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_BUILD = 3'b010,
      ST_EMIT  = 3'b100
   } back_state_type;

   back_state_type     state_ff, state_in;
   g4t_pkg::job_type   job_ff, job_in_q;
   logic [15:0]        ink_ff [g4t_pkg::CELL_SIZE];
   logic [15:0]        ink_in [g4t_pkg::CELL_SIZE];
   logic [15:0]        prev_ff, prev_in;
   logic [4:0]         row_ff, row_in;
   logic [8:0]         bit_ff, bit_in;
   logic [1:0]         step_ff, step_in;
   logic [15:0]        win_ff, win_in;
   logic               rd_zero_ff, rd_zero_in;
   logic [4:0]         word_ff, word_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        tile_ff, tile_in;
   logic [4:0]         index_ff, index_in;
   logic               last_ff, last_in;

   logic [6:0]         byte_addr;
   logic [7:0]         rbyte;
   logic [23:0]        win24;
   logic [23:0]        shifted;
   logic [15:0]        row_bits;
   logic [3:0]         ink_row_idx;
   logic               rows_done;
   logic               out_free;

   function automatic logic [31:0] shade_word(input logic [15:0] cur,
                                              input logic [15:0] prev,
                                              input logic half);
      logic [7:0]  cur_half;
      logic [7:0]  up_left;
      logic [31:0] word;
      cur_half = half ? cur[15:8] : cur[7:0];
      up_left  = half ? prev[14:7] : {prev[6:0], 1'b0};
      word     = '0;
      for (int x = 0; x < 8; x++) begin
         if (cur_half[x]) begin
            word[4*x +: 4] = g4t_pkg::PIX_INK;
         end else if (up_left[x]) begin
            word[4*x +: 4] = g4t_pkg::PIX_SHADOW;
         end else begin
            word[4*x +: 4] = g4t_pkg::PIX_EMPTY;
         end
      end
      return word;
   endfunction

   assign byte_addr   = {1'b0, bit_ff[8:3]} + {5'b0, step_ff};
   assign rd_zero_in  = byte_addr >= 7'(g4t_pkg::MAX_STREAM_BYTES);
   assign ram_rd_addr = byte_addr[g4t_pkg::ADDR_W-1:0];
   assign rbyte       = rd_zero_ff ? 8'h00 : ram_rd_data;

   assign win24       = {win_ff, rbyte};
   assign shifted     = win24 << bit_ff[2:0];
   assign ink_row_idx = job_ff.row_offset + row_ff[3:0];
   assign rows_done   = (row_ff >= job_ff.glyph_rows) ||
                        (({2'b0, job_ff.row_offset} + {1'b0, row_ff}) >=
                         6'(g4t_pkg::CELL_SIZE));
   assign out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      for (int x = 0; x < 16; x++) begin
         row_bits[x] = shifted[23 - x] && (5'(x) < job_ff.glyph_width);
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in_q     = job_ff;
      ink_in       = ink_ff;
      prev_in      = prev_ff;
      row_in       = row_ff;
      bit_in       = bit_ff;
      step_in      = step_ff;
      win_in       = win_ff;
      word_in      = word_ff;
      rsp_valid_in = rsp_valid_ff;
      tile_in      = tile_ff;
      index_in     = index_ff;
      last_in      = last_ff;
      job_pop      = 1'b0;
      map_done     = 1'b0;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               job_in_q = job_in;
               for (int i = 0; i < g4t_pkg::CELL_SIZE; i++) begin
                  ink_in[i] = '0;
               end
               row_in   = '0;
               bit_in   = '0;
               step_in  = '0;
               state_in = ST_BUILD;
            end
         end
         ST_BUILD: begin
            if (rows_done) begin
               map_done = 1'b1;
               word_in  = '0;
               prev_in  = '0;
               state_in = ST_EMIT;
            end else begin
               case (step_ff)
                  2'd0: step_in = 2'd1;
                  2'd1, 2'd2: begin
                     win_in  = {win_ff[7:0], rbyte};
                     step_in = step_ff + 2'd1;
                  end
                  2'd3: begin
                     ink_in[ink_row_idx] = row_bits;
                     row_in  = row_ff + 5'd1;
                     bit_in  = bit_ff + {4'b0, job_ff.glyph_width};
                     step_in = 2'd0;
                  end
                  default: step_in = 2'd0;
               endcase
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               tile_in      = shade_word(ink_ff[0], prev_ff, word_ff[4]);
               index_in     = word_ff;
               last_in      = word_ff == g4t_pkg::WORD_LAST;
               word_in      = word_ff + 5'd1;
               prev_in      = (word_ff[3:0] == 4'hF) ? 16'h0000 : ink_ff[0];
               for (int i = 0; i < g4t_pkg::CELL_SIZE - 1; i++) begin
                  ink_in[i] = ink_ff[i + 1];
               end
               ink_in[g4t_pkg::CELL_SIZE - 1] = ink_ff[0];
               if (word_ff == g4t_pkg::WORD_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in_q;
      ink_ff     <= ink_in;
      prev_ff    <= prev_in;
      row_ff     <= row_in;
      bit_ff     <= bit_in;
      step_ff    <= step_in;
      win_ff     <= win_in;
      rd_zero_ff <= rd_zero_in;
      word_ff    <= word_in;
      tile_ff    <= tile_in;
      index_ff   <= index_in;
      last_ff    <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tile_word  = tile_ff;
   assign rsp_word_index = index_ff;
   assign rsp_cell_last  = last_ff;

endmodule

`default_nettype wire

// ===== sv/glyph_1bpp_to_shadowed_4bpp_tiles_unit.sv =====
// glyph_1bpp_to_shadowed_4bpp_tiles_unit: top level of the glyph tile unit
// depends on g4t_pkg, g4t_ram, g4t_front, g4t_jobq, g4t_back
//
// Usage:
// - req channel: one byte of the packed 1bpp glyph per transaction, rows MSB
//   first with no padding; req_stream_last marks the final byte of a glyph.
// - rsp channel: 32 transactions per glyph, word index 0..31, rsp_cell_last on
//   word 31; four 8x8 4bpp tiles in the order TL, BL, TR, BR.
// - csr port: glyph_width (0), glyph_rows (1), row_offset (2); the user must
//   write it only while the unit is idle, the unit does not enforce this.
// - Bytes are taken one per cycle, while req_ready is high, into the bit buffer ram.
// - After the last byte the back end builds the ink map, reading three bytes per
//   placed row through the one ram read port before it writes the row. req_ready
//   stays low from the last byte until the map is built; the next glyph's bytes
//   then load while the words go out.
// - Words leave one per cycle from an output register while rsp_ready stays
//   high; the emit state after the map build loads the first word into it.
// - A stalled receiver holds the output register and the word sequencer;
//   nothing is dropped.
// - Reset clears the config registers to 11, 11, 1, the byte count, the job
//   queue and the output valid; the bit buffer is not cleared.
`default_nettype none

module glyph_1bpp_to_shadowed_4bpp_tiles_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [7:0]                        req_stream_byte,
   input  wire logic                              req_stream_last,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [31:0]                       rsp_tile_word,
   output logic      [4:0]                        rsp_word_index,
   output logic                                   rsp_cell_last,
   input  wire logic                              csr_we,
   input  wire logic [g4t_pkg::CFG_IDX_W-1:0]     csr_index,
   input  wire logic [g4t_pkg::CFG_DATA_W-1:0]    csr_data
);

   logic                          ram_wr_en;
   logic [g4t_pkg::ADDR_W-1:0]    ram_wr_addr;
   logic [7:0]                    ram_wr_data;
   logic [g4t_pkg::ADDR_W-1:0]    ram_rd_addr;
   logic [7:0]                    ram_rd_data;
   logic                          job_push;
   g4t_pkg::job_type              push_job;
   logic                          job_full;
   logic                          job_pop;
   g4t_pkg::job_type              pop_job;
   logic                          job_empty;
   logic                          map_done;

   g4t_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .req_stream_last (req_stream_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .job_push        (job_push),
      .job_out         (push_job),
      .job_full        (job_full),
      .map_done        (map_done)
   );

   g4t_ram #(
      .WIDTH (8),
      .DEPTH (g4t_pkg::MAX_STREAM_BYTES)
   ) u_bit_buffer (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   g4t_jobq u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (job_full),
      .pop      (job_pop),
      .pop_job  (pop_job),
      .empty    (job_empty)
   );

   g4t_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_empty      (job_empty),
      .job_in         (pop_job),
      .job_pop        (job_pop),
      .map_done       (map_done),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tile_word  (rsp_tile_word),
      .rsp_word_index (rsp_word_index),
      .rsp_cell_last  (rsp_cell_last)
   );

endmodule

`default_nettype wire

// ===== sv/g4t_checker.sv =====
// g4t_checker: port level assertions for the glyph tile unit, bound to the top
// depends on g4t_pkg and glyph_1bpp_to_shadowed_4bpp_tiles_unit
`default_nettype none

module g4t_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              req_stream_last,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [31:0]                       rsp_tile_word,
   input wire logic [4:0]                        rsp_word_index,
   input wire logic                              rsp_cell_last
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tile_word) &&
                                  $stable(rsp_word_index) && $stable(rsp_cell_last))
      else $error("rsp transaction changed while stalled");

   // no result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // cell_last marks word 31 only
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cell_last == (rsp_word_index == g4t_pkg::WORD_LAST)))
      else $error("rsp_cell_last does not match word index");

   // words of a cell come out in index order
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_cell_last |=>
         !rsp_valid || (rsp_word_index == $past(rsp_word_index) + 5'd1))
      else $error("rsp word index out of sequence");

   // input closes after the last byte of a glyph
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_stream_last |=> !req_ready)
      else $error("req_ready high right after last transaction");

endmodule

bind glyph_1bpp_to_shadowed_4bpp_tiles_unit g4t_checker u_g4t_checker (.*);

`default_nettype wire
